// ===== design/v3n_pkg.sv =====
// ============================================================================
// v3n_pkg - shared types and constants for the vector normalize unit
// Beat structs for the command and result sides, plus datapath widths.
// ============================================================================
package v3n_pkg;

    localparam int COMP_W      = 32;            // component and result width
    localparam int SUM_W       = 64;            // sum of squares
    localparam int SHIFT_W     = 5;             // half of the normalizing shift
    localparam int ROOT_W      = 33;            // root of the 66-bit radicand
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int REM_W       = ROOT_W + 4;
    localparam int QUOT_W      = 31;            // unit magnitude, at most 2^30
    localparam int Q30_SHIFT   = 30;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = QUOT_W;
    localparam int LANES       = 3;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic        [COMP_W-1:0] length;
        logic                     zero_vector;
    } out_beat_t;

endpackage

// ===== design/vec3_normalize_unit.sv =====
// ============================================================================
// vec3_normalize_unit - length and unit vector of a 3-component vector
// Pipelined sum of squares, digit-recurrence square root and three
// restoring dividers, one vector per cycle.
// ============================================================================
// Usage:
//   A command beat (operand, Q.16 components) is taken on every clock edge
//   where start is high; busy is tied low, so a new vector can be issued
//   every cycle. Each vector yields one result beat (result) marked by done
//   for a single cycle, after passing the input, square, sum, leading-zero,
//   normalize, square-root, divider-setup, divider and output registers.
//   Throughput is one vector per cycle: the 33-step square root and the
//   31-step dividers are unrolled into one register stage per step.
//   result.length is the rounded Euclidean length (Q.16), unit_* are Q2.30.
//   A zero vector sets zero_vector and returns zero length and components.
//   The receiver cannot stall; results must be taken as they appear.
//   Reset (rst_n low, asynchronous) clears every stage valid, dropping any
//   vectors in flight; no result is issued until new commands arrive.
// ============================================================================
module vec3_normalize_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  v3n_pkg::in_beat_t  operand,
    output logic               done,
    output v3n_pkg::out_beat_t result
);
    import v3n_pkg::*;

    typedef struct packed {
        logic [LANES-1:0][COMP_W-1:0] mag;
        logic [LANES-1:0]             neg;
    } side_t;

    typedef struct packed {
        logic               valid;
        side_t              side;
        logic [SUM_W-1:0]   val;     // squares summed or not yet
        logic [LANES-1:0][SUM_W-1:0] sq;
    } front_t;

    typedef struct packed {
        logic               valid;
        side_t              side;
        logic               zero;
        logic [SHIFT_W-1:0] k;
        logic [RAD_W-1:0]   rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } sqrt_t;

    typedef struct packed {
        logic                           valid;
        logic                           zero;
        logic [LANES-1:0]               neg;
        logic [COMP_W-1:0]              length;
        logic [ROOT_W-1:0]              lp;
        logic [LANES-1:0][ROOT_W-1:0]   rem;
        logic [LANES-1:0][QUOT_W-1:0]   num;
        logic [LANES-1:0][QUOT_W-1:0]   quo;
    } div_t;

    front_t in_reg, in_next, mul_reg, mul_next, sum_reg, sum_next;
    logic [3:0][4:0] cz_reg, cz_next;
    front_t clz_reg;
    sqrt_t  norm_reg, norm_next;
    sqrt_t  sqrt_reg  [SQRT_STAGES];
    sqrt_t  sqrt_next [SQRT_STAGES];
    div_t   post_reg, post_next;
    div_t   div_reg   [DIV_STAGES];
    div_t   div_next  [DIV_STAGES];
    logic      out_valid_reg;
    out_beat_t out_reg, out_next;

    assign busy = 1'b0;

    // ---- magnitudes
    always_comb
    begin
        logic [LANES-1:0][COMP_W-1:0] raw;
        raw = {operand.comp_x, operand.comp_y, operand.comp_z};
        in_next = '0;
        in_next.valid = start;
        for (int i = 0; i < LANES; i++)
        begin
            in_next.side.neg[i] = raw[i][COMP_W-1];
            in_next.side.mag[i] = raw[i][COMP_W-1] ? (~raw[i] + 1'b1) : raw[i];
        end
    end

    // ---- squares
    always_comb
    begin
        mul_next = in_reg;
        for (int i = 0; i < LANES; i++)
            mul_next.sq[i] = SUM_W'(in_reg.side.mag[i]) * SUM_W'(in_reg.side.mag[i]);
    end

    // ---- sum (3 * 2^62 fits 64 bits)
    always_comb
    begin
        sum_next = mul_reg;
        sum_next.val = mul_reg.sq[0] + mul_reg.sq[1] + mul_reg.sq[2];
    end

    // ---- leading zeros per 16-bit chunk
    always_comb
    begin
        logic [15:0] ch;
        logic        hit;
        for (int c = 0; c < 4; c++)
        begin
            ch  = sum_reg.val[c*16 +: 16];
            hit = 1'b0;
            cz_next[c] = 5'd16;
            for (int b = 15; b >= 0; b--)
            begin
                if (!hit && ch[b])
                begin
                    cz_next[c] = 5'(15 - b);
                    hit = 1'b1;
                end
            end
        end
    end

    // ---- normalize: k = floor(clz/2), radicand = (S << 2k) << 2
    always_comb
    begin
        logic [6:0] lz;
        logic       hit;
        lz  = 7'd64;
        hit = 1'b0;
        for (int c = 3; c >= 0; c--)
        begin
            if (!hit && cz_reg[c] != 5'd16)
            begin
                lz  = 7'((3 - c) * 16) + 7'(cz_reg[c]);
                hit = 1'b1;
            end
        end
        norm_next       = '0;
        norm_next.valid = clz_reg.valid;
        norm_next.side  = clz_reg.side;
        norm_next.zero  = (clz_reg.val == '0);
        norm_next.k     = hit ? lz[5:1] : '0;
        norm_next.rad   = {clz_reg.val << {norm_next.k, 1'b0}, 2'b00};
    end

    // ---- square root, one root bit per stage
    always_comb
    begin
        sqrt_t            src;
        logic [REM_W-1:0] r2;
        logic [REM_W-1:0] trial;
        for (int i = 0; i < SQRT_STAGES; i++)
        begin
            src   = (i == 0) ? norm_reg : sqrt_reg[(i == 0) ? 0 : i - 1];
            r2    = {src.rem[REM_W-3:0], src.rad[RAD_W-1 -: 2]};
            trial = {2'b00, src.root, 2'b01};
            sqrt_next[i]     = src;
            sqrt_next[i].rad = {src.rad[RAD_W-3:0], 2'b00};
            if (r2 >= trial)
            begin
                sqrt_next[i].rem  = r2 - trial;
                sqrt_next[i].root = {src.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sqrt_next[i].rem  = r2;
                sqrt_next[i].root = {src.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // ---- rounding and divider setup
    // F = floor(2^(k+1) sqrt S): L' = (F+1)/2, length = ((F>>k)+1)/2
    always_comb
    begin
        sqrt_t              s;
        logic [ROOT_W-1:0]  fk;
        logic [ROOT_W:0]    lp1;
        logic [ROOT_W:0]    len1;
        logic [COMP_W-1:0]  m2k;
        logic [2*QUOT_W:0]  num;
        s    = sqrt_reg[SQRT_STAGES-1];
        fk   = s.root >> s.k;
        lp1  = {1'b0, s.root} + 1'b1;
        len1 = {1'b0, fk} + 1'b1;
        post_next        = '0;
        post_next.valid  = s.valid;
        post_next.zero   = s.zero;
        post_next.neg    = s.side.neg;
        post_next.lp     = lp1[ROOT_W:1];
        post_next.length = len1[COMP_W:1];
        for (int i = 0; i < LANES; i++)
        begin
            m2k = s.side.mag[i] << s.k;   // bounded by sqrt of the radicand
            num = {1'b0, m2k, {Q30_SHIFT{1'b0}}} + (2*QUOT_W+1)'(lp1[ROOT_W:2]);
            post_next.rem[i] = ROOT_W'(num[2*QUOT_W:QUOT_W]);
            post_next.num[i] = num[QUOT_W-1:0];
        end
    end

    // ---- restoring dividers, one quotient bit per stage
    always_comb
    begin
        div_t              src;
        logic [ROOT_W:0]   r2;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            src = (j == 0) ? post_reg : div_reg[(j == 0) ? 0 : j - 1];
            div_next[j] = src;
            for (int i = 0; i < LANES; i++)
            begin
                r2 = {src.rem[i], src.num[i][QUOT_W-1]};
                div_next[j].num[i] = {src.num[i][QUOT_W-2:0], 1'b0};
                if (r2 >= {1'b0, src.lp})
                begin
                    div_next[j].rem[i] = ROOT_W'(r2 - {1'b0, src.lp});
                    div_next[j].quo[i] = {src.quo[i][QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    div_next[j].rem[i] = r2[ROOT_W-1:0];
                    div_next[j].quo[i] = {src.quo[i][QUOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // ---- sign, clamp, zero forcing
    always_comb
    begin
        div_t                         d;
        logic [QUOT_W-1:0]            q;
        logic [LANES-1:0][COMP_W-1:0] u;
        d = div_reg[DIV_STAGES-1];
        for (int i = 0; i < LANES; i++)
        begin
            q = (d.quo[i] > QUOT_W'(1) << Q30_SHIFT) ? QUOT_W'(1) << Q30_SHIFT : d.quo[i];
            u[i] = d.zero ? '0
                 : (d.neg[i] ? (~{1'b0, q} + 1'b1) : {1'b0, q});
        end
        out_next.unit_x      = u[2];
        out_next.unit_y      = u[1];
        out_next.unit_z      = u[0];
        out_next.length      = d.zero ? '0 : d.length;
        out_next.zero_vector = d.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg        <= '0;
            mul_reg       <= '0;
            sum_reg       <= '0;
            clz_reg       <= '0;
            cz_reg        <= '0;
            norm_reg      <= '0;
            post_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < SQRT_STAGES; i++)
                sqrt_reg[i] <= '0;
            for (int j = 0; j < DIV_STAGES; j++)
                div_reg[j] <= '0;
        end
        else
        begin
            in_reg        <= in_next;
            mul_reg       <= mul_next;
            sum_reg       <= sum_next;
            clz_reg       <= sum_reg;
            cz_reg        <= cz_next;
            norm_reg      <= norm_next;
            post_reg      <= post_next;
            out_valid_reg <= div_reg[DIV_STAGES-1].valid;
            out_reg       <= out_next;
            for (int i = 0; i < SQRT_STAGES; i++)
                sqrt_reg[i] <= sqrt_next[i];
            for (int j = 0; j < DIV_STAGES; j++)
                div_reg[j] <= div_next[j];
        end
    end

    assign done   = out_valid_reg;
    assign result = out_reg;

    // ---- checks
    a_zero_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.zero_vector |->
            result.length == '0 && result.unit_x == '0 &&
            result.unit_y == '0 && result.unit_z == '0)
        else $error("zero vector beat carries nonzero data");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.zero_vector |-> result.length != '0)
        else $error("nonzero vector gave zero length");

    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.unit_x <= 32'sh4000_0000 && result.unit_x >= -32'sh4000_0000 &&
                 result.unit_y <= 32'sh4000_0000 && result.unit_y >= -32'sh4000_0000 &&
                 result.unit_z <= 32'sh4000_0000 && result.unit_z >= -32'sh4000_0000)
        else $error("unit component out of range");

endmodule

// ===== tb/tb.sv =====
// ============================================================================
// tb - vector normalize unit testbench
// Drives vectors through the command port, predicts length and unit vector
// with exact integer math, and checks each result beat in order.
// ============================================================================
module tb;
    import v3n_pkg::*;

    localparam int LATENCY   = 71;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 750;

    // expected beats plus mismatch bookkeeping
    class norm_scoreboard;
        out_beat_t pending[$];
        int        n_err;

        function new();
            n_err = 0;
        endfunction

        static function logic [63:0] sqrt_nearest(logic [63:0] v);
            logic [63:0] rem;
            logic [63:0] res;
            logic [63:0] bitv;
            rem  = v;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (rem >= res + bitv)
                begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            if (v - res * res > res)
                res = res + 1;
            return res;
        endfunction

        static function out_beat_t normalize(in_beat_t vin);
            out_beat_t     r;
            logic [31:0]   raw[3];
            logic [63:0]   mag[3];
            logic          neg[3];
            logic [63:0]   sumsq;
            logic [63:0]   scaled;
            logic [63:0]   root_s;
            logic [127:0]  q;
            logic [31:0]   u[3];
            int            k;
            raw[0] = vin.comp_x;
            raw[1] = vin.comp_y;
            raw[2] = vin.comp_z;
            sumsq = 0;
            for (int i = 0; i < 3; i++)
            begin
                neg[i] = raw[i][31];
                mag[i] = neg[i] ? (64'd1 << 32) - {32'd0, raw[i]} : {32'd0, raw[i]};
                sumsq  = sumsq + mag[i] * mag[i];
            end
            r = '0;
            if (sumsq == 0)
            begin
                r.zero_vector = 1'b1;
                return r;
            end
            r.length = 32'(sqrt_nearest(sumsq));
            scaled = sumsq;
            k = 0;
            while (scaled[63:62] == 2'b00)
            begin
                scaled = scaled << 2;
                k++;
            end
            root_s = sqrt_nearest(scaled);
            for (int i = 0; i < 3; i++)
            begin
                q = (({64'd0, mag[i]} << k) << 30) + (root_s >> 1);
                q = q / root_s;
                if (q > (128'd1 << 30))
                    q = 128'd1 << 30;
                u[i] = neg[i] ? -q[31:0] : q[31:0];
            end
            r.unit_x = u[0];
            r.unit_y = u[1];
            r.unit_z = u[2];
            return r;
        endfunction

        function void note_vector(in_beat_t vin);
            pending.push_back(normalize(vin));
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t exp_b;
            if (pending.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result beat %h", got);
                return;
            end
            exp_b = pending.pop_front();
            if (got.unit_x !== exp_b.unit_x || got.unit_y !== exp_b.unit_y ||
                got.unit_z !== exp_b.unit_z || got.length !== exp_b.length ||
                got.zero_vector !== exp_b.zero_vector)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: exp x=%h y=%h z=%h len=%h zv=%b got x=%h y=%h z=%h len=%h zv=%b",
                             exp_b.unit_x, exp_b.unit_y, exp_b.unit_z, exp_b.length,
                             exp_b.zero_vector, got.unit_x, got.unit_y, got.unit_z,
                             got.length, got.zero_vector);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_beat_t  operand;
    logic      done;
    out_beat_t result;

    norm_scoreboard sb;
    int             wdog;
    bit             quiet_tail;

    vec3_normalize_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        operand = '0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_vector(operand);
            if (done)
                sb.check_result(result);
            if ((start && !busy) || done)
                wdog <= 0;
            else
                wdog <= wdog + 1;
        end
    end

    always @(posedge clk)
    begin
        if (wdog >= WDOG_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // holds one beat until accepted; a random gap follows now and then
    task automatic send_vector(in_beat_t v);
        int gap;
        start   <= 1'b1;
        operand <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            3: return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
            4: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_beat_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_beat_t v;
        v.comp_x = x;
        v.comp_y = y;
        v.comp_z = z;
        return v;
    endfunction

    initial
    begin
        in_beat_t v;
        sb = new();
        wdog = 0;
        quiet_tail = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero vector, extremes, axes, tiny and mixed signs
        send_vector(mk(0, 0, 0));
        send_vector(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_vector(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_vector(mk(32'h8000_0000, 0, 0));
        send_vector(mk(0, 32'h8000_0000, 0));
        send_vector(mk(0, 0, 32'h8000_0000));
        send_vector(mk(32'h7FFF_FFFF, 0, 0));
        send_vector(mk(1, 0, 0));
        send_vector(mk(0, 32'hFFFF_FFFF, 0));
        send_vector(mk(0, 0, 1));
        send_vector(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_vector(mk(32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000));
        send_vector(mk(3, 4, 0));
        send_vector(mk(32'h7FFF_FFFF, 32'h8000_0000, 1));
        send_vector(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF));
        send_vector(mk(0, 0, 0));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i > N_RANDOM - 100)
                quiet_tail = 1'b1;
            v = mk(rand_comp(), rand_comp(), rand_comp());
            send_vector(v);
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (sb.n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
